// ----- rtl/sample_stats_longest_run_unit_assert.svh -----
// Assertion macros shared by the sample statistics RTL.
// Needs nothing else; files that check their own logic include it.
`ifndef SAMPLE_STATS_LONGEST_RUN_UNIT_ASSERT_SVH
`define SAMPLE_STATS_LONGEST_RUN_UNIT_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define SSLR_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define SSLR_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define SSLR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/sslr_pkg.sv -----
// Shared types and constants of the sample statistics block.
// No dependencies; imported by the ALU, the register file, the core and the top level.
package sslr_pkg;

   localparam int SAMPLE_FIELD_W = 16;
   localparam int RSP_TDATA_W    = 72;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [15:0] THRESHOLD_RESET = 16'd500;

   // Register index, taken from the word address bits of paddr.
   localparam logic [CSR_ADDR_W-3:0] REG_RUN_THRESHOLD = 1'b0;

   typedef enum logic [0:0] {
      ALU_SUB = 1'b0,
      ALU_ADD = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [10:0] sample_total;
      logic [9:0]  min_index;
      logic [9:0]  max_index;
      logic [15:0] mean_value;
      logic        run_found;
      logic [9:0]  run_start;
      logic [9:0]  run_end;
      logic        overflowed;
   } rsp_item_type;

endpackage

// ----- rtl/sample_stats_longest_run_unit.sv -----
// Top level of the sample statistics block: stream ports, result register, registers.
// Depends on sslr_pkg, sslr_csr and sslr_core (which uses sslr_alu).

// Each sample is taken while the sequencer is idle and then worked through one shared
// add/subtract unit by a sequencer in the minimum, maximum, threshold and sum steps, with
// run length and run compare steps added when a run above the threshold ends. A sample that
// arrives after the set is full is dropped, but if it is flagged last it still closes the set. The sample flagged
// last adds the run length and compare steps to close an open run, a step to form the dividend and
// min(SAMPLE_BITS,16)+clog2(MAX_SAMPLES+1)+1 divide steps for the mean (28 at the
// defaults), then waits in a done state until the output register takes the result. req_tready is
// high only while the sequencer is idle. A finished result waits in the output register,
// so a new set can start while it is still not taken.
module sample_stats_longest_run_unit #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata: [15:0] sample_value
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,
   input  logic                             req_tlast,
   // rsp_tdata: [10:0] sample_total, [20:11] min_index, [30:21] max_index,
   // [46:31] mean_value, [47] run_found, [57:48] run_start, [67:58] run_end,
   // [68] overflowed, [71:69] zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sslr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sslr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sslr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sslr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import sslr_pkg::*;

   logic [15:0]            run_threshold;
   logic                   result_valid;
   logic                   result_ready;
   rsp_item_type           result_item;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   sslr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .run_threshold (run_threshold)
   );

   sslr_core #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (req_tvalid),
      .item_ready    (req_tready),
      .item_sample   (req_tdata),
      .item_last     (req_tlast),
      .run_threshold (run_threshold),
      .result_valid  (result_valid),
      .result_ready  (result_ready),
      .result_item   (result_item)
   );

   // The result register takes a new result when empty or when its transfer completes.
   assign result_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (result_valid && result_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000,
                         result_item.overflowed,
                         result_item.run_end,
                         result_item.run_start,
                         result_item.run_found,
                         result_item.mean_value,
                         result_item.max_index,
                         result_item.min_index,
                         result_item.sample_total};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/sslr_alu.sv -----
// Shared add/subtract unit of the sample statistics core.
// Depends on sslr_pkg for the operation codes.
module sslr_alu #(
   parameter int WIDTH = 17
) (
   input  sslr_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]     operand_a,
   input  logic [WIDTH-1:0]     operand_b,
   output logic [WIDTH-1:0]     result,
   output logic                 borrow
);
   import sslr_pkg::*;

   logic [WIDTH-1:0] b_eff;
   logic             carry_in;
   logic             carry_out;

   // One adder serves both operations; subtraction adds the complement plus one.
   always_comb begin
      unique case (op)
         ALU_ADD: begin
            b_eff    = operand_b;
            carry_in = 1'b0;
         end
         ALU_SUB: begin
            b_eff    = ~operand_b;
            carry_in = 1'b1;
         end
         default: begin
            b_eff    = ~operand_b;
            carry_in = 1'b1;
         end
      endcase
   end

   assign {carry_out, result} = {1'b0, operand_a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, carry_in};

   // For a subtraction a missing carry means operand_a < operand_b.
   assign borrow = (op == ALU_SUB) && !carry_out;

endmodule

// ----- rtl/sslr_csr.sv -----
// Configuration register file of the sample statistics block: the run threshold.
// Depends on sslr_pkg for the address map and the reset value.
module sslr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sslr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sslr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sslr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic [15:0]                      run_threshold
);
   import sslr_pkg::*;

   logic [15:0]           threshold_ff;
   logic [15:0]           threshold_in;
   logic [CSR_ADDR_W-3:0] reg_index;
   logic                  write_now;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign write_now  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      if (write_now && (reg_index == REG_RUN_THRESHOLD)) begin
         threshold_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_RUN_THRESHOLD) begin
         csr_prdata = CSR_DATA_W'(threshold_ff);
      end
   end

   assign run_threshold = threshold_ff;

endmodule

// ----- rtl/sslr_core.sv -----
// Sequencer and set state of the sample statistics block.
// Depends on sslr_pkg, sslr_alu and the assertion macro header.
`include "sample_stats_longest_run_unit_assert.svh"

module sslr_core #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  logic [15:0]           item_sample,
   input  logic                  item_last,
   input  logic [15:0]           run_threshold,
   output logic                  result_valid,
   input  logic                  result_ready,
   output sslr_pkg::rsp_item_type result_item
);
   import sslr_pkg::*;

   localparam int VAL_W  = (SAMPLE_BITS < SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W  = $clog2(MAX_SAMPLES);
   localparam int SUM_W  = VAL_W + CNT_W;
   localparam int NUM_W  = SUM_W + 1;
   localparam int ALU_W  = (SUM_W + 2 > 17) ? SUM_W + 2 : 17;
   localparam int ITER_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_SAMPLES);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_MIN   = 10'b0000000010,
      S_MAX   = 10'b0000000100,
      S_THR   = 10'b0000001000,
      S_SUM   = 10'b0000010000,
      S_RLEN  = 10'b0000100000,
      S_RCMP  = 10'b0001000000,
      S_DINIT = 10'b0010000000,
      S_DIV   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [VAL_W-1:0]   sample_ff, sample_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;
   logic [VAL_W-1:0]   low_val_ff, low_val_in;
   logic [IDX_W-1:0]   low_pos_ff, low_pos_in;
   logic [VAL_W-1:0]   high_val_ff, high_val_in;
   logic [IDX_W-1:0]   high_pos_ff, high_pos_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               in_run_ff, in_run_in;
   logic [IDX_W-1:0]   run_begin_ff, run_begin_in;
   logic [CNT_W-1:0]   best_len_ff, best_len_in;
   logic [IDX_W-1:0]   best_begin_ff, best_begin_in;
   logic [IDX_W-1:0]   best_finish_ff, best_finish_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   close_end_ff, close_end_in;
   logic               at_end_ff, at_end_in;
   logic [CNT_W-1:0]   run_len_ff, run_len_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [CNT_W:0]     rem_ff, rem_in;
   logic [ITER_W-1:0]  iter_ff, iter_in;

   alu_op_type         alu_op;
   logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
   logic               alu_borrow;
   logic [IDX_W-1:0]   idx;
   logic [CNT_W-1:0]   close_last;
   logic               first_sample;
   logic               run_found;

   assign idx          = seen_ff[IDX_W-1:0];
   assign close_last   = close_end_ff - CNT_W'(1);
   assign first_sample = (seen_ff == '0);
   assign item_ready   = (state_ff == S_IDLE);
   assign result_valid = (state_ff == S_DONE);

   sslr_alu #(.WIDTH(ALU_W)) u_alu (
      .op        (alu_op),
      .operand_a (alu_a),
      .operand_b (alu_b),
      .result    (alu_res),
      .borrow    (alu_borrow)
   );

   // Operand selection for the shared unit, one use per sequencer step.
   always_comb begin
      alu_op = ALU_SUB;
      alu_a  = '0;
      alu_b  = '0;
      unique case (state_ff)
         S_MIN: begin
            alu_a = ALU_W'(sample_ff);
            alu_b = ALU_W'(low_val_ff);
         end
         S_MAX: begin
            alu_a = ALU_W'(high_val_ff);
            alu_b = ALU_W'(sample_ff);
         end
         S_THR: begin
            alu_a = ALU_W'(run_threshold);
            alu_b = ALU_W'(sample_ff);
         end
         S_SUM: begin
            alu_op = ALU_ADD;
            alu_a  = ALU_W'(sum_ff);
            alu_b  = ALU_W'(sample_ff);
         end
         S_RLEN: begin
            alu_a = ALU_W'(close_end_ff);
            alu_b = ALU_W'(run_begin_ff);
         end
         S_RCMP: begin
            alu_a = ALU_W'(best_len_ff);
            alu_b = ALU_W'(run_len_ff);
         end
         S_DINIT: begin
            alu_op = ALU_ADD;
            alu_a  = ALU_W'({sum_ff, 1'b0});
            alu_b  = ALU_W'(seen_ff);
         end
         S_DIV: begin
            alu_a = ALU_W'({rem_ff, num_ff[NUM_W-1]});
            alu_b = ALU_W'({seen_ff, 1'b0});
         end
         S_IDLE, S_DONE: begin
            alu_a = '0;
            alu_b = '0;
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      sample_in      = sample_ff;
      last_in        = last_ff;
      seen_in        = seen_ff;
      low_val_in     = low_val_ff;
      low_pos_in     = low_pos_ff;
      high_val_in    = high_val_ff;
      high_pos_in    = high_pos_ff;
      sum_in         = sum_ff;
      in_run_in      = in_run_ff;
      run_begin_in   = run_begin_ff;
      best_len_in    = best_len_ff;
      best_begin_in  = best_begin_ff;
      best_finish_in = best_finish_ff;
      ovf_in         = ovf_ff;
      close_end_in   = close_end_ff;
      at_end_in      = at_end_ff;
      run_len_in     = run_len_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;
      iter_in        = iter_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               sample_in = item_sample[VAL_W-1:0];
               last_in   = item_last;
               if (seen_ff == FULL_COUNT) begin
                  // The set is full: the sample is dropped, but a last flag still closes it.
                  ovf_in = 1'b1;
                  if (item_last) begin
                     if (in_run_ff) begin
                        close_end_in = seen_ff;
                        at_end_in    = 1'b1;
                        state_in     = S_RLEN;
                     end else begin
                        state_in = S_DINIT;
                     end
                  end
               end else begin
                  state_in = S_MIN;
               end
            end
         end
         S_MIN: begin
            if (first_sample || alu_borrow) begin
               low_val_in = sample_ff;
               low_pos_in = idx;
            end
            state_in = S_MAX;
         end
         S_MAX: begin
            if (first_sample || alu_borrow) begin
               high_val_in = sample_ff;
               high_pos_in = idx;
            end
            state_in = S_THR;
         end
         S_THR: begin
            state_in = S_SUM;
            if (alu_borrow) begin
               if (!in_run_ff) begin
                  in_run_in    = 1'b1;
                  run_begin_in = idx;
               end
            end else if (in_run_ff) begin
               // The run ended at the previous sample.
               close_end_in = seen_ff;
               at_end_in    = 1'b0;
               state_in     = S_RLEN;
            end
         end
         S_SUM: begin
            sum_in  = alu_res[SUM_W-1:0];
            seen_in = seen_ff + CNT_W'(1);
            if (last_ff) begin
               if (in_run_ff) begin
                  close_end_in = seen_ff + CNT_W'(1);
                  at_end_in    = 1'b1;
                  state_in     = S_RLEN;
               end else begin
                  state_in = S_DINIT;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RLEN: begin
            run_len_in = alu_res[CNT_W-1:0];
            state_in   = S_RCMP;
         end
         S_RCMP: begin
            // Only a strictly longer run replaces the best one.
            if (alu_borrow) begin
               best_len_in    = run_len_ff;
               best_begin_in  = run_begin_ff;
               best_finish_in = close_last[IDX_W-1:0];
            end
            in_run_in = 1'b0;
            state_in  = at_end_ff ? S_DINIT : S_SUM;
         end
         S_DINIT: begin
            // Dividend 2*sum + count over divisor 2*count rounds the mean half up.
            num_in   = alu_res[NUM_W-1:0];
            rem_in   = '0;
            iter_in  = ITER_W'(NUM_W - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (alu_borrow) begin
               rem_in = {rem_ff[CNT_W-1:0], num_ff[NUM_W-1]};
            end else begin
               rem_in = alu_res[CNT_W:0];
            end
            num_in = {num_ff[NUM_W-2:0], !alu_borrow};
            if (iter_ff == '0) begin
               state_in = S_DONE;
            end else begin
               iter_in = iter_ff - ITER_W'(1);
            end
         end
         S_DONE: begin
            if (result_ready) begin
               seen_in        = '0;
               low_val_in     = '0;
               low_pos_in     = '0;
               high_val_in    = '0;
               high_pos_in    = '0;
               sum_in         = '0;
               in_run_in      = 1'b0;
               run_begin_in   = '0;
               best_len_in    = '0;
               best_begin_in  = '0;
               best_finish_in = '0;
               ovf_in         = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         seen_ff        <= '0;
         low_val_ff     <= '0;
         low_pos_ff     <= '0;
         high_val_ff    <= '0;
         high_pos_ff    <= '0;
         sum_ff         <= '0;
         in_run_ff      <= 1'b0;
         run_begin_ff   <= '0;
         best_len_ff    <= '0;
         best_begin_ff  <= '0;
         best_finish_ff <= '0;
         ovf_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seen_ff        <= seen_in;
         low_val_ff     <= low_val_in;
         low_pos_ff     <= low_pos_in;
         high_val_ff    <= high_val_in;
         high_pos_ff    <= high_pos_in;
         sum_ff         <= sum_in;
         in_run_ff      <= in_run_in;
         run_begin_ff   <= run_begin_in;
         best_len_ff    <= best_len_in;
         best_begin_ff  <= best_begin_in;
         best_finish_ff <= best_finish_in;
         ovf_ff         <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      last_ff      <= last_in;
      close_end_ff <= close_end_in;
      at_end_ff    <= at_end_in;
      run_len_ff   <= run_len_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      iter_ff      <= iter_in;
   end

   assign run_found = (best_len_ff != '0);

   always_comb begin
      result_item.sample_total = 11'(seen_ff);
      result_item.min_index    = 10'(low_pos_ff);
      result_item.max_index    = 10'(high_pos_ff);
      result_item.mean_value   = first_sample ? 16'd0 : 16'(num_ff[VAL_W-1:0]);
      result_item.run_found    = run_found;
      result_item.run_start    = run_found ? 10'(best_begin_ff) : 10'd0;
      result_item.run_end      = run_found ? 10'(best_finish_ff) : 10'd0;
      result_item.overflowed   = ovf_ff;
   end

   `SSLR_ASSERT_ALWAYS(a_count_in_range, clock, reset, seen_ff <= FULL_COUNT, "sample count beyond capacity")
   `SSLR_ASSERT_IMPLY(a_open_run_begins_early, clock, reset, (state_ff == S_IDLE) && in_run_ff, CNT_W'(run_begin_ff) < seen_ff, "open run starts at or after the sample count")
   `SSLR_ASSERT_IMPLY(a_best_run_fits, clock, reset, state_ff == S_IDLE, best_len_ff <= seen_ff, "best run longer than the set")
   `SSLR_ASSERT_IMPLY(a_min_below_max, clock, reset, (state_ff == S_IDLE) && !first_sample, low_val_ff <= high_val_ff, "minimum above maximum")
   `SSLR_ASSERT_NEXT(a_set_cleared, clock, reset, (state_ff == S_DONE) && result_ready, (seen_ff == '0) && !in_run_ff && !ovf_ff, "set state not cleared after a result")

endmodule
